// File: rtl/euler_to_quaternion_core_defines.svh
// Assertion macros for the file that checks its own logic.
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

// The condition holds whenever the trigger holds, in the same cycle.
`define E2Q_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define E2Q_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Constants and constant tables of the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 14;
	localparam int QUAT_BITS        = 16;
	// Cosine and sine travel as Q20 with two integer bits of headroom.
	localparam int CS_BITS          = 22;
	// CORDIC datapath width, Q32 with headroom for half angles up to about 4.
	localparam int CORD_BITS        = 36;
	localparam int COMB_LATENCY     = 4;
	localparam int QUAT_ONE         = 16384;

	// atan(2^-i) in Q32, rounded to nearest.
	function automatic longint atan_q32(input int i);
		real r;
		r = $atan(2.0 ** (-i)) * (2.0 ** 32);
		return longint'(r);
	endfunction

	// pi/2 in Q32, rounded to nearest.
	function automatic longint half_pi_q32();
		real r;
		r = $atan(1.0) * 2.0 * (2.0 ** 32);
		return longint'(r);
	endfunction

	// CORDIC gain over the given number of steps in Q32, truncated.
	function automatic longint gain_q32(input int steps);
		real g;
		g = 1.0;
		for (int i = 0; i < steps; i++) begin
			g = g * ((1.0 + (4.0 ** (-i))) ** (-0.5));
		end
		return longint'($floor(g * (2.0 ** 32)));
	endfunction

endpackage

// File: rtl/e2q_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_angle_if / e2q_quat_if
// Valid/ready channels for the Euler angle requests and the quaternions.
// ----------------------------------------------------------------------------
interface e2q_angle_if #(parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;

	modport source (output valid, pitch_angle, roll_angle, yaw_angle, input ready);
	modport sink   (input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if;
	import e2q_pkg::*;
	logic                        valid;
	logic                        ready;
	logic signed [QUAT_BITS-1:0] quat_w;
	logic signed [QUAT_BITS-1:0] quat_x;
	logic signed [QUAT_BITS-1:0] quat_y;
	logic signed [QUAT_BITS-1:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: rtl/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation CORDIC: cosine and sine of half an angle, in Q20.
// ----------------------------------------------------------------------------
module e2q_cordic #(
	parameter int ANGLE_BITS   = e2q_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [ANGLE_BITS-1:0]       angle,
	output logic signed [e2q_pkg::CS_BITS-1:0] cos_q20,
	output logic signed [e2q_pkg::CS_BITS-1:0] sin_q20
);
	import e2q_pkg::*;

	localparam int W = CORD_BITS;
	localparam logic signed [W-1:0] HALF_PI = W'(half_pi_q32());
	localparam logic signed [W-1:0] GAIN    = W'(gain_q32(CORDIC_STEPS));
	localparam logic signed [W-1:0] RND     = W'(2048);

	logic signed [W-1:0] z_in;
	logic signed [W-1:0] x_s [0:CORDIC_STEPS];
	logic signed [W-1:0] y_s [0:CORDIC_STEPS];
	logic signed [W-1:0] z_s [0:CORDIC_STEPS];
	logic                neg_s [0:CORDIC_STEPS];
	logic signed [W-1:0] xr;
	logic signed [W-1:0] yr;

	// Q3.(ANGLE_BITS-3) radians shifted into a Q32 half angle.
	assign z_in = W'(angle) <<< (34 - ANGLE_BITS);

	// Fold half angles beyond a quarter turn back and flip the result signs.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GAIN;
			y_s[0] <= '0;
			if (z_in > HALF_PI) begin
				z_s[0]   <= z_in - (HALF_PI <<< 1);
				neg_s[0] <= 1'b1;
			end else if (z_in < -HALF_PI) begin
				z_s[0]   <= z_in + (HALF_PI <<< 1);
				neg_s[0] <= 1'b1;
			end else begin
				z_s[0]   <= z_in;
				neg_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [W-1:0] ATAN = W'(atan_q32(i));
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
			end
		end
	end

	assign xr = (x_s[CORDIC_STEPS] + RND) >>> 12;
	assign yr = (y_s[CORDIC_STEPS] + RND) >>> 12;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q20 <= neg_s[CORDIC_STEPS] ? -xr[CS_BITS-1:0] : xr[CS_BITS-1:0];
			sin_q20 <= neg_s[CORDIC_STEPS] ? -yr[CS_BITS-1:0] : yr[CS_BITS-1:0];
		end
	end

endmodule

// File: rtl/e2q_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_combine
// Triple products of the half angle cosines and sines, summed, rounded to
// Q1.14 and saturated to plus or minus one.
// ----------------------------------------------------------------------------
module e2q_combine (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [e2q_pkg::CS_BITS-1:0]   cp,
	input  logic signed [e2q_pkg::CS_BITS-1:0]   sp,
	input  logic signed [e2q_pkg::CS_BITS-1:0]   cr,
	input  logic signed [e2q_pkg::CS_BITS-1:0]   sr,
	input  logic signed [e2q_pkg::CS_BITS-1:0]   cy,
	input  logic signed [e2q_pkg::CS_BITS-1:0]   sy,
	output logic signed [e2q_pkg::QUAT_BITS-1:0] quat_w,
	output logic signed [e2q_pkg::QUAT_BITS-1:0] quat_x,
	output logic signed [e2q_pkg::QUAT_BITS-1:0] quat_y,
	output logic signed [e2q_pkg::QUAT_BITS-1:0] quat_z
);
	import e2q_pkg::*;

	localparam int CW = CS_BITS;
	localparam int PW = 2 * CW;
	localparam int TW = 3 * CW;
	localparam int SW = TW + 1;
	localparam logic signed [SW-1:0] RND = SW'(1) <<< 46 >>> 1;
	localparam logic signed [SW-1:0] POS_ONE = SW'(QUAT_ONE);
	localparam logic signed [SW-1:0] NEG_ONE = -SW'(QUAT_ONE);

	// Pair index: 0 cy*cr, 1 sy*sr, 2 cy*sr, 3 sy*cr. Pitch index: 0 cos, 1 sin.
	logic signed [PW-1:0]   pair_s1 [4];
	logic signed [CW-1:0]   pc_s1 [2];
	logic signed [PW-1:0]   hi_s2 [4][2];
	logic signed [PW:0]     lo_s2 [4][2];
	logic signed [TW-1:0]   tri_s3 [4][2];
	logic signed [SW-1:0]   sum [4];
	logic signed [SW-1:0]   rnd [4];
	logic signed [QUAT_BITS-1:0] sat [4];

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1[0] <= cy * cr;
			pair_s1[1] <= sy * sr;
			pair_s1[2] <= cy * sr;
			pair_s1[3] <= sy * cr;
			pc_s1[0]   <= cp;
			pc_s1[1]   <= sp;
		end
	end

	// Each wide pair product is split into a signed high half and an unsigned
	// low half so that no multiplier exceeds the pair width.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 4; p++) begin
				for (int c = 0; c < 2; c++) begin
					hi_s2[p][c] <= $signed(pair_s1[p][PW-1:CW]) * pc_s1[c];
					lo_s2[p][c] <= $signed({1'b0, pair_s1[p][CW-1:0]}) * pc_s1[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 4; p++) begin
				for (int c = 0; c < 2; c++) begin
					tri_s3[p][c] <= (TW'(hi_s2[p][c]) <<< CW) + TW'(lo_s2[p][c]);
				end
			end
		end
	end

	always_comb begin
		sum[0] = SW'(tri_s3[0][0]) + SW'(tri_s3[1][1]);
		sum[1] = SW'(tri_s3[2][0]) - SW'(tri_s3[3][1]);
		sum[2] = SW'(tri_s3[0][1]) + SW'(tri_s3[1][0]);
		sum[3] = SW'(tri_s3[3][0]) - SW'(tri_s3[2][1]);
		for (int k = 0; k < 4; k++) begin
			rnd[k] = (sum[k] + RND) >>> 46;
			if (rnd[k] > POS_ONE) begin
				sat[k] = QUAT_BITS'(QUAT_ONE);
			end else if (rnd[k] < NEG_ONE) begin
				sat[k] = -QUAT_BITS'(QUAT_ONE);
			end else begin
				sat[k] = rnd[k][QUAT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_w <= sat[0];
			quat_x <= sat[1];
			quat_y <= sat[2];
			quat_z <= sat[3];
		end
	end

endmodule

// File: rtl/euler_to_quaternion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// ZYX Euler angles in Q3.13 radians to a unit quaternion in Q1.14.
// ----------------------------------------------------------------------------
//  Channel   Role     Payload
//  angles    sink     pitch_angle, roll_angle, yaw_angle
//  quat      source   quat_w, quat_x, quat_y, quat_z
//
// One request enters per cycle while the output is not stalled; the pipeline
// holds one CORDIC step per stage plus fold, rounding and four product stages.
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stalled result at the output freezes the whole pipeline, and input
// ready is low exactly while that stall lasts.
module euler_to_quaternion_core #(
	parameter int ANGLE_BITS   = e2q_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	e2q_angle_if.sink   angles,
	e2q_quat_if.source  quat
);
	import e2q_pkg::*;
	`include "euler_to_quaternion_core_defines.svh"

	localparam int LAT = CORDIC_STEPS + 2 + COMB_LATENCY;

	logic                      en;
	logic [LAT-1:0]            vld_q;
	logic signed [CS_BITS-1:0] cp, sp, cr, sr, cy, sy;

	assign en           = ~vld_q[LAT-1] | quat.ready;
	assign angles.ready = en;
	assign quat.valid   = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], angles.valid};
		end
	end

	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .angle(angles.pitch_angle), .cos_q20(cp), .sin_q20(sp)
	);
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .angle(angles.roll_angle), .cos_q20(cr), .sin_q20(sr)
	);
	e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(en), .angle(angles.yaw_angle), .cos_q20(cy), .sin_q20(sy)
	);

	e2q_combine u_comb (
		.clk(clk), .en(en),
		.cp(cp), .sp(sp), .cr(cr), .sr(sr), .cy(cy), .sy(sy),
		.quat_w(quat.quat_w), .quat_x(quat.quat_x),
		.quat_y(quat.quat_y), .quat_z(quat.quat_z)
	);

	`E2Q_ASSERT_NEXT(a_accept_enters, angles.valid && angles.ready, vld_q[0], "accepted request lost")
	`E2Q_ASSERT_SAME(a_stall_blocks, quat.valid && !quat.ready, !angles.ready, "input taken during stall")
	`E2Q_ASSERT_SAME(a_w_range, quat.valid, quat.quat_w <= 16'sd16384 && quat.quat_w >= -16'sd16384, "w beyond one")
	`E2Q_ASSERT_SAME(a_x_range, quat.valid, quat.quat_x <= 16'sd16384 && quat.quat_x >= -16'sd16384, "x beyond one")

endmodule
